// ===== src/efg_pkg.sv =====
package efg_pkg;

  localparam int NUM_GROUPS     = 8;
  localparam int MAX_TASK_SLOTS = 16;

  localparam int CMD_W   = 2;
  localparam int GRP_W   = 3;
  localparam int FLAG_W  = 32;
  localparam int TASK_W  = 4;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;
  localparam int WOKEN_W = 16;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [GRP_W-1:0]   grp_t;
  typedef logic [FLAG_W-1:0]  flag_t;
  typedef logic [TASK_W-1:0]  task_idx_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STAT_W-1:0]  stat_t;
  typedef logic [WOKEN_W-1:0] woken_t;

  localparam cmd_t CMD_CREATE = 2'd0;
  localparam cmd_t CMD_POST   = 2'd1;
  localparam cmd_t CMD_ACCEPT = 2'd2;
  localparam cmd_t CMD_PEND   = 2'd3;

  localparam stat_t STAT_OK          = 2'd0;
  localparam stat_t STAT_NOT_SET     = 2'd1;
  localparam stat_t STAT_BLOCKED     = 2'd2;
  localparam stat_t STAT_NOT_ENABLED = 2'd3;

  // Operations of the shared flag logic unit
  typedef enum logic [1:0] {
    OP_TEST = 2'd0,
    OP_OR   = 2'd1,
    OP_CLR  = 2'd2
  } unit_op_t;

  // Requests from the sequencer to the task wait cells
  typedef struct packed {
    logic      release_grp;
    logic      mark;
    grp_t      grp;
    task_idx_t task_req;
  } task_ctrl_t;

endpackage

// ===== src/event_flag_group_unit.sv =====
// Event-flag unit with eight flag groups and sixteen task wait cells. A command is
// taken when start is high and busy is low; its one result appears on the out_
// ports for a single cycle, marked by out_valid, and must be captured then, as
// the unit cannot be held off. Every step of a command goes through one shared
// 32-bit flag logic unit (test, set, clear), once per cycle. The result strobe
// follows the check step for create and for commands rejected for unenabled bits,
// the exec step for post, accept and pend, and a further clear step for a
// consuming success. busy drops in the cycle the result is shown, so the next
// command may be issued then. A post releases in parallel every task that waits
// on the posted group below task_count. task_count is to be written through cfg_
// only while the unit is idle, not enforced by the unit; cfg_ready is always high.
module event_flag_group_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  efg_pkg::cmd_t          in_command,
  input  efg_pkg::grp_t          in_flag_group,
  input  efg_pkg::flag_t         in_mask,
  input  logic                   in_consume,
  input  efg_pkg::task_idx_t     in_task_req,
  output logic                   out_valid,
  output efg_pkg::stat_t         out_status,
  output efg_pkg::flag_t         out_flags_now,
  output efg_pkg::woken_t        out_woken_tasks,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  efg_pkg::count_t        cfg_task_count
);
  import efg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  count_t     task_count_r;
  flag_t      enable_r [NUM_GROUPS];
  flag_t      value_r  [NUM_GROUPS];

  cmd_t       cmd_r;
  grp_t       grp_r;
  flag_t      mask_r;
  logic       consume_r;
  task_idx_t  task_req_r;

  logic       out_valid_r, out_valid_nxt;
  stat_t      status_r, status_nxt;
  flag_t      flags_r, flags_nxt;
  woken_t     woken_r, woken_nxt;

  logic       en_we, val_we;
  flag_t      en_wdata, val_wdata;
  flag_t      en_sel, val_sel;
  logic       grp_in_range;

  unit_op_t   unit_op;
  flag_t      unit_a, unit_res;
  logic       unit_all_set;

  task_ctrl_t task_ctrl;
  woken_t     cell_woken;
  logic       accept;

  assign accept       = start && !busy;
  assign busy         = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign en_sel       = enable_r[grp_r];
  assign val_sel      = value_r[grp_r];
  assign grp_in_range = ({1'b0, grp_r} < (GRP_W + 1)'(NUM_GROUPS));

  efg_logic_unit u_logic (
    .op      (unit_op),
    .a       (unit_a),
    .b       (mask_r),
    .res     (unit_res),
    .all_set (unit_all_set)
  );

  efg_task_cells u_cells (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (task_ctrl),
    .task_count (task_count_r),
    .woken      (cell_woken)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STAT_OK;
    flags_nxt     = '0;
    woken_nxt     = '0;
    en_we         = 1'b0;
    val_we        = 1'b0;
    en_wdata      = mask_r;
    val_wdata     = unit_res;
    unit_op       = OP_TEST;
    unit_a        = val_sel;
    task_ctrl     = '{release_grp: 1'b0, mark: 1'b0, grp: grp_r, task_req: task_req_r};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        unit_a = en_sel;
        priority if (!grp_in_range) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_NOT_ENABLED;
        end else if (cmd_r == CMD_CREATE) begin
          en_we         = 1'b1;
          val_we        = 1'b1;
          val_wdata     = '0;
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (!unit_all_set) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_NOT_ENABLED;
          flags_nxt     = val_sel;
        end else begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (cmd_r == CMD_POST) begin
          unit_op               = OP_OR;
          val_we                = 1'b1;
          task_ctrl.release_grp = 1'b1;
          state_nxt             = ST_IDLE;
          out_valid_nxt         = 1'b1;
          flags_nxt             = unit_res;
          woken_nxt             = cell_woken;
        end else begin
          priority if (unit_all_set && consume_r) begin
            state_nxt = ST_CLEAR;
          end else if (unit_all_set) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            flags_nxt     = val_sel;
          end else if (cmd_r == CMD_ACCEPT) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            status_nxt    = STAT_NOT_SET;
            flags_nxt     = val_sel;
          end else begin
            // Pend failed: park the requesting task on this group
            task_ctrl.mark = 1'b1;
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            status_nxt     = STAT_BLOCKED;
            flags_nxt      = val_sel;
          end
        end
      end

      ST_CLEAR: begin
        unit_op       = OP_CLR;
        val_we        = 1'b1;
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        flags_nxt     = unit_res;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      task_count_r <= '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        enable_r[i] <= '0;
        value_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        task_count_r <= cfg_task_count;
      end
      if (en_we) begin
        enable_r[grp_r] <= en_wdata;
      end
      if (val_we) begin
        value_r[grp_r] <= val_wdata;
      end
    end
  end

  // Hold the transaction fields and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_command;
      grp_r      <= in_flag_group;
      mask_r     <= in_mask;
      consume_r  <= in_consume;
      task_req_r <= in_task_req;
    end
    if (out_valid_nxt) begin
      status_r <= status_nxt;
      flags_r  <= flags_nxt;
      woken_r  <= woken_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_flags_now   = flags_r;
  assign out_woken_tasks = woken_r;

endmodule

// ===== src/efg_logic_unit.sv =====
module efg_logic_unit (
  input  efg_pkg::unit_op_t op,
  input  efg_pkg::flag_t    a,
  input  efg_pkg::flag_t    b,
  output efg_pkg::flag_t    res,
  output logic              all_set
);
  import efg_pkg::*;

  flag_t masked;

  assign masked  = a & b;
  assign all_set = (masked == b);

  always_comb begin
    unique case (op)
      OP_TEST: res = masked;
      OP_OR:   res = a | b;
      OP_CLR:  res = a & ~b;
      default: res = masked;
    endcase
  end

endmodule

// ===== src/efg_task_cells.sv =====
module efg_task_cells (
  input  logic                clk,
  input  logic                rst_n,
  input  efg_pkg::task_ctrl_t ctrl,
  input  efg_pkg::count_t     task_count,
  output efg_pkg::woken_t     woken
);
  import efg_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASK_SLOTS + 1);

  logic [MAX_TASK_SLOTS-1:0] blocked_r;
  logic [MAX_TASK_SLOTS-1:0] wait_valid_r;
  grp_t                      wait_grp_r [MAX_TASK_SLOTS];
  logic [MAX_TASK_SLOTS-1:0] hit;
  logic                      mark_ok;

  // A cell releases when it sits below the scan limit and waits on the posted group
  always_comb begin
    for (int i = 0; i < MAX_TASK_SLOTS; i++) begin
      hit[i] = ctrl.release_grp && wait_valid_r[i] && (wait_grp_r[i] == ctrl.grp)
               && (IDX_W'(i) < IDX_W'(task_count));
    end
  end

  always_comb begin
    woken = '0;
    for (int i = 0; i < MAX_TASK_SLOTS; i++) begin
      if (i < WOKEN_W) begin
        woken[i] = hit[i] && blocked_r[i];
      end
    end
  end

  assign mark_ok = ctrl.mark && ({1'b0, ctrl.task_req} < (TASK_W + 1)'(MAX_TASK_SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_r    <= '0;
      wait_valid_r <= '0;
      for (int i = 0; i < MAX_TASK_SLOTS; i++) begin
        wait_grp_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_TASK_SLOTS; i++) begin
        if (hit[i]) begin
          blocked_r[i] <= 1'b0;
        end
      end
      if (mark_ok) begin
        blocked_r[ctrl.task_req]    <= 1'b1;
        wait_valid_r[ctrl.task_req] <= 1'b1;
        wait_grp_r[ctrl.task_req]   <= ctrl.grp;
      end
    end
  end

endmodule
